// ===== hw/rtl/lpsb_pkg.sv =====
`default_nettype none

package lpsb_pkg;

    // Capacity limits of the design
    localparam int MAX_PANELS_DEFAULT = 16;
    localparam int ADDR_MAX_W         = 12;   // enough for 64 * 64 scan bytes

    // Configuration register file
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PANELS_ACROSS = 2'd0,
        CFG_PANELS_DOWN   = 2'd1,
        CFG_SERPENTINE    = 2'd2
    } lpsb_cfg_index_t;

    // Operation codes carried in the mode field
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_READ  = 1'b1;

    // Mapping result handed from the address mapper to the store
    typedef struct packed {
        logic                  wr_ok;    // write lands inside the display
        logic                  rd_ok;    // read lies inside the stream
        logic [2:0]            bit_sel;  // bit position within the scan byte
        logic [ADDR_MAX_W-1:0] addr;     // scan byte address
    } lpsb_map_t;

endpackage

`default_nettype wire

// ===== hw/rtl/led_panel_scan_buffer.sv =====
`default_nettype none

// Quarter-scan shift memory for a chain of 32x16 monochrome LED panels.
// Pulse start with mode 0 to set or clear one pixel (pixel_x, pixel_y,
// pixel_on), or with mode 1 to fetch one scan byte (scan_phase, byte_index)
// for the panel shifter. A transaction is taken on any clock where start is
// high and busy is low; one can be issued every cycle. Its result passes the
// command and result registers to read_byte / accepted, marked by a one-cycle
// done pulse; the receiver cannot stall it, so results must be captured when
// done is high. accepted is 0 for pixels off the display or past the store's
// capacity and for bytes past the end of the configured stream; read_byte is
// 0 for writes and rejected reads. After reset, busy stays high while a sweep
// zeroes the store one byte per cycle. The panel geometry registers are
// written through cfg_wr_en / cfg_index / cfg_data and should only change
// while no transaction is in flight; they do not move the store.
module led_panel_scan_buffer #(
    parameter int MAX_PANELS = lpsb_pkg::MAX_PANELS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration port
    input  logic                             cfg_wr_en,
    input  logic [lpsb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    // command side
    input  logic                             start,
    output logic                             busy,
    input  logic                             mode,
    input  logic [8:0]                       pixel_x,
    input  logic [7:0]                       pixel_y,
    input  logic                             pixel_on,
    input  logic [1:0]                       scan_phase,
    input  logic [7:0]                       byte_index,
    // result side
    output logic                             done,
    output logic [7:0]                       read_byte,
    output logic                             accepted
);

    import lpsb_pkg::*;

    localparam int DEPTH = 64 * MAX_PANELS;
    localparam int AW    = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Configuration registers (raw values; clamping happens in the mapper)
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] panels_across_reg;
    logic [CFG_DATA_W-1:0] panels_down_reg;
    logic                  serpentine_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panels_across_reg <= CFG_DATA_W'(1);
            panels_down_reg   <= CFG_DATA_W'(1);
            serpentine_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PANELS_ACROSS: panels_across_reg <= cfg_data;
                CFG_PANELS_DOWN:   panels_down_reg   <= cfg_data;
                CFG_SERPENTINE:    serpentine_reg    <= cfg_data[0];
                default:           ;  // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Post-reset clear sweep
    // ------------------------------------------------------------------
    logic          clearing_reg;
    logic [AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    assign busy = clearing_reg;

    // ------------------------------------------------------------------
    // Stage 1: command register
    // ------------------------------------------------------------------
    logic       s1_valid_reg;
    logic       s1_mode_reg;
    logic [8:0] s1_x_reg;
    logic [7:0] s1_y_reg;
    logic       s1_on_reg;
    logic [1:0] s1_phase_reg;
    logic [7:0] s1_byte_reg;
    logic       take;

    assign take = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_mode_reg  <= mode;
            s1_x_reg     <= pixel_x;
            s1_y_reg     <= pixel_y;
            s1_on_reg    <= pixel_on;
            s1_phase_reg <= scan_phase;
            s1_byte_reg  <= byte_index;
        end
    end

    // ------------------------------------------------------------------
    // Address mapping (combinational, between stage 1 and the store)
    // ------------------------------------------------------------------
    lpsb_map_t map;

    lpsb_map #(
        .MAX_PANELS (MAX_PANELS)
    ) u_map (
        .panels_across (panels_across_reg),
        .panels_down   (panels_down_reg),
        .serpentine    (serpentine_reg),
        .mode          (s1_mode_reg),
        .pixel_x       (s1_x_reg),
        .pixel_y       (s1_y_reg),
        .scan_phase    (s1_phase_reg),
        .byte_index    (s1_byte_reg),
        .map           (map)
    );

    // ------------------------------------------------------------------
    // Scan store: one single-bit RAM per bit lane, so a pixel write only
    // touches its own lane and needs no read-modify-write.
    // ------------------------------------------------------------------
    logic          item_wr;
    logic          item_rd;
    logic [AW-1:0] item_addr;
    logic [7:0]    lane_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [7:0]    ram_q;

    assign item_wr   = s1_valid_reg && map.wr_ok;
    assign item_rd   = s1_valid_reg && map.rd_ok;
    assign item_addr = map.addr[AW-1:0];
    assign ram_waddr = clearing_reg ? clr_cnt_reg : item_addr;
    assign ram_wdata = clearing_reg ? 1'b0 : s1_on_reg;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lane_we[i] = clearing_reg || (item_wr && (map.bit_sel == 3'(i)));
        end
    end

    for (genvar g = 0; g < 8; g++)
    begin : g_lane
        lpsb_ram #(
            .WIDTH (1),
            .DEPTH (DEPTH)
        ) u_ram (
            .clk     (clk),
            .wr_en   (lane_we[g]),
            .wr_addr (ram_waddr),
            .wr_data (ram_wdata),
            .rd_en   (item_rd),
            .rd_addr (item_addr),
            .rd_data (ram_q[g])
        );
    end

    // ------------------------------------------------------------------
    // Stage 2: result register (RAM output register holds the byte)
    // ------------------------------------------------------------------
    logic done_reg;
    logic accepted_reg;
    logic rd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            rd_hit_reg   <= 1'b0;
        end
        else
        begin
            done_reg     <= s1_valid_reg;
            accepted_reg <= s1_valid_reg && (map.wr_ok || map.rd_ok);
            rd_hit_reg   <= item_rd;
        end
    end

    assign done      = done_reg;
    assign accepted  = accepted_reg;
    assign read_byte = rd_hit_reg ? ram_q : 8'd0;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_latency : assert property (@(posedge clk) disable iff (!rst_n)
        take |-> ##2 done)
        else $error("transaction result not delivered two cycles after start");

    a_byte_only_when_accepted : assert property (@(posedge clk) disable iff (!rst_n)
        (read_byte != 8'd0) |-> (done && accepted))
        else $error("nonzero read_byte without an accepted result");

    a_clear_runs_full : assert property (@(posedge clk) disable iff (!rst_n)
        $fell(clearing_reg) |-> ($past(clr_cnt_reg) == AW'(DEPTH - 1)))
        else $error("clear sweep ended before covering the store");

    a_single_lane : assert property (@(posedge clk) disable iff (!rst_n)
        !clearing_reg |-> ($countones(lane_we) <= 1))
        else $error("pixel write touched more than one bit lane");

    a_no_access_in_clear : assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !(item_wr || item_rd))
        else $error("store access during clear sweep");

endmodule

`default_nettype wire

// ===== hw/rtl/lpsb_ram.sv =====
`default_nettype none

module lpsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lpsb_map.sv =====
`default_nettype none

module lpsb_map #(
    parameter int MAX_PANELS = lpsb_pkg::MAX_PANELS_DEFAULT
) (
    input  logic [lpsb_pkg::CFG_DATA_W-1:0] panels_across,
    input  logic [lpsb_pkg::CFG_DATA_W-1:0] panels_down,
    input  logic                            serpentine,
    input  logic                            mode,
    input  logic [8:0]                      pixel_x,
    input  logic [7:0]                      pixel_y,
    input  logic [1:0]                      scan_phase,
    input  logic [7:0]                      byte_index,
    output lpsb_pkg::lpsb_map_t             map
);

    import lpsb_pkg::*;

    localparam int PHASE_STRIDE = 16 * MAX_PANELS;

    function automatic logic [4:0] clamp_panels(input logic [4:0] v);
        logic [4:0] r;
        if (v == 5'd0)
        begin
            r = 5'd1;
        end
        else if (v > 5'd16)
        begin
            r = 5'd16;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    logic [4:0]            pa;
    logic [4:0]            pd;
    logic [3:0]            px;
    logic [3:0]            py;
    logic [4:0]            lx;
    logic [3:0]            ly;
    logic                  mirror;
    logic                  in_display;
    logic [4:0]            px_chain;
    logic [8:0]            panel;
    logic                  panel_ok;
    logic [3:0]            byte_in_panel;
    logic [ADDR_MAX_W-1:0] phase_base_w;
    logic [ADDR_MAX_W-1:0] addr_w;
    logic [9:0]            total;
    logic [9:0]            total_c;
    logic [13:0]           stream_len;
    logic                  rd_in;
    logic [ADDR_MAX_W-1:0] addr_r;

    always_comb
    begin
        pa = clamp_panels(panels_across);
        pd = clamp_panels(panels_down);

        // write path: panel, then phase / byte / bit inside the panel
        px         = pixel_x[8:5];
        py         = pixel_y[7:4];
        ly         = pixel_y[3:0];
        in_display = ({1'b0, px} < pa) && ({1'b0, py} < pd);
        mirror     = serpentine & py[0];
        px_chain   = mirror ? (pa - 5'd1 - {1'b0, px}) : {1'b0, px};
        lx         = mirror ? ~pixel_x[4:0] : pixel_x[4:0];   // 31 - lx
        panel      = ({5'd0, py} * {4'd0, pa}) + {4'd0, px_chain};
        panel_ok   = panel < 9'(MAX_PANELS);

        // quarter scan: the bottom row group (rows 12..15) comes first in the byte order
        byte_in_panel = {lx[4:3], ~ly[3:2]};
        phase_base_w  = ADDR_MAX_W'({10'd0, ly[1:0]} * 12'(PHASE_STRIDE));
        addr_w        = phase_base_w + ADDR_MAX_W'({panel, 4'd0})
                        + ADDR_MAX_W'(byte_in_panel);

        // read path: stream length limited by store capacity
        total      = {5'd0, pa} * {5'd0, pd};
        total_c    = (total > 10'(MAX_PANELS)) ? 10'(MAX_PANELS) : total;
        stream_len = {total_c, 4'd0};
        rd_in      = {6'd0, byte_index} < stream_len;
        addr_r     = ADDR_MAX_W'({10'd0, scan_phase} * 12'(PHASE_STRIDE))
                     + ADDR_MAX_W'(byte_index);

        map.wr_ok   = (mode == MODE_WRITE) && in_display && panel_ok;
        map.rd_ok   = (mode == MODE_READ) && rd_in;
        map.bit_sel = ~lx[2:0];
        map.addr    = (mode == MODE_READ) ? addr_r : addr_w;
    end

endmodule

`default_nettype wire

// ===== tb/sv/led_panel_scan_buffer_checker.sv =====
`timescale 1ns / 100ps

// Watches both sides of the scan buffer, keeps a shadow copy of the scan store
// and geometry, and checks each done pulse against the oldest owed result.
module led_panel_scan_buffer_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [lpsb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lpsb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             start,
    input  logic                             busy,
    input  logic                             mode,
    input  logic [8:0]                       pixel_x,
    input  logic [7:0]                       pixel_y,
    input  logic                             pixel_on,
    input  logic [1:0]                       scan_phase,
    input  logic [7:0]                       byte_index,
    input  logic                             done,
    input  logic [7:0]                       read_byte,
    input  logic                             accepted,
    output int                               mismatch_count,
    output int                               pending_count
);
    import lpsb_pkg::*;

    localparam int PANEL_CAP    = MAX_PANELS_DEFAULT;
    localparam int PHASE_STRIDE = 16 * PANEL_CAP;
    localparam int STORE_DEPTH  = 4 * PHASE_STRIDE;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       accepted;
    } scan_result_t;

    logic [7:0]   shadow_store [STORE_DEPTH];
    logic [4:0]   shadow_across;
    logic [4:0]   shadow_down;
    logic         shadow_serp;
    scan_result_t owed_results [$];

    // 0 behaves as 1, anything above 16 as 16
    function automatic int panel_count(input logic [4:0] raw);
        if (raw == 5'd0) return 1;
        if (raw > 5'd16) return 16;
        return int'(raw);
    endfunction

    // Applies one transaction to the shadow store and returns its result.
    function automatic scan_result_t scan_access(input logic op, input logic [8:0] x_in,
            input logic [7:0] y_in, input logic on, input logic [1:0] ph_in,
            input logic [7:0] bi_in);
        int pa, pd, xi, yi, px, py, lx, ly, panel, addr, span, ph, bi;
        scan_result_t res;
        res = '0;
        pa  = panel_count(shadow_across);
        pd  = panel_count(shadow_down);
        xi  = int'(x_in);
        yi  = int'(y_in);
        ph  = int'(ph_in);
        bi  = int'(bi_in);
        if (op == MODE_WRITE) begin
            if (xi < 32 * pa && yi < 16 * pd) begin
                px = xi / 32;
                py = yi / 16;
                lx = xi % 32;
                ly = yi % 16;
                if (shadow_serp && (py % 2 == 1)) begin
                    panel = py * pa + (pa - 1 - px);
                    lx    = 31 - lx;
                end else begin
                    panel = py * pa + px;
                end
                if (panel < PANEL_CAP) begin
                    // rows 12..15 land in sub-byte 0, rows 0..3 in sub-byte 3
                    addr = (ly % 4) * PHASE_STRIDE + panel * 16
                         + ((lx / 8) % 4) * 4 + (3 - (ly / 4));
                    shadow_store[addr][7 - (lx % 8)] = on;
                    res.accepted = 1'b1;
                end
            end
        end else begin
            span = pa * pd;
            if (span > PANEL_CAP) span = PANEL_CAP;
            if (bi < 16 * span) begin
                res.read_byte = shadow_store[ph * PHASE_STRIDE + bi];
                res.accepted  = 1'b1;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        scan_result_t want;
        if (!rst_n) begin
            for (int i = 0; i < STORE_DEPTH; i++) shadow_store[i] = 8'h00;
            shadow_across  = 5'd1;
            shadow_down    = 5'd1;
            shadow_serp    = 1'b0;
            owed_results.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end else begin
            if (done) begin
                if (owed_results.size() == 0) begin
                    $display("%0t: unexpected result read_byte=%0h accepted=%0b",
                             $time, read_byte, accepted);
                    mismatch_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (read_byte !== want.read_byte) begin
                        $display("%0t: read_byte expected %0h actual %0h",
                                 $time, want.read_byte, read_byte);
                        mismatch_count++;
                    end
                    if (accepted !== want.accepted) begin
                        $display("%0t: accepted expected %0b actual %0b",
                                 $time, want.accepted, accepted);
                        mismatch_count++;
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PANELS_ACROSS: shadow_across = cfg_data;
                    CFG_PANELS_DOWN:   shadow_down   = cfg_data;
                    CFG_SERPENTINE:    shadow_serp   = cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy)
                owed_results.push_back(scan_access(mode, pixel_x, pixel_y, pixel_on,
                                                   scan_phase, byte_index));
            pending_count = owed_results.size();
        end
    end

endmodule

// ===== tb/sv/led_panel_scan_buffer_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the LED panel scan buffer. All prediction and
// checking happens in the checker instance; this module only drives.
module led_panel_scan_buffer_tb;
    import lpsb_pkg::*;

    // index 3 has no register behind it; writes there must be ignored
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 2'd3;
    localparam int ROUNDS         = 12;
    localparam int ITEMS_PER_ROUND = 162;
    // result arrives through the command and result registers; drain adds margin
    localparam int DRAIN_CYCLES   = 4;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   start;
    logic                   busy;
    logic                   mode;
    logic [8:0]             pixel_x;
    logic [7:0]             pixel_y;
    logic                   pixel_on;
    logic [1:0]             scan_phase;
    logic [7:0]             byte_index;
    logic                   done;
    logic [7:0]             read_byte;
    logic                   accepted;
    int                     mismatch_count;
    int                     pending_count;

    led_panel_scan_buffer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_on   (pixel_on),
        .scan_phase (scan_phase),
        .byte_index (byte_index),
        .done       (done),
        .read_byte  (read_byte),
        .accepted   (accepted)
    );

    led_panel_scan_buffer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .pixel_on       (pixel_on),
        .scan_phase     (scan_phase),
        .byte_index     (byte_index),
        .done           (done),
        .read_byte      (read_byte),
        .accepted       (accepted),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Present one transaction at the falling edge and hold it until a rising
    // edge sees busy low. busy read right after the edge is its pre-edge value,
    // which is exactly what decided acceptance.
    task automatic issue(input logic op, input logic [8:0] x, input logic [7:0] y,
                         input logic on, input logic [1:0] ph, input logic [7:0] bi);
        @(negedge clk);
        start      <= 1'b1;
        mode       <= op;
        pixel_x    <= x;
        pixel_y    <= y;
        pixel_on   <= on;
        scan_phase <= ph;
        byte_index <= bi;
        do @(posedge clk); while (busy);
    endtask

    // Idles the command side with start low; payload wiggles as noise.
    task automatic idle_cycle();
        @(negedge clk);
        start      <= 1'b0;
        mode       <= 1'($urandom);
        pixel_x    <= 9'($urandom);
        pixel_y    <= 8'($urandom);
        pixel_on   <= 1'($urandom);
        scan_phase <= 2'($urandom);
        byte_index <= 8'($urandom);
    endtask

    // Stop issuing, let every owed result come back, then allow the pipe
    // to drain before touching registers or ending the run.
    task automatic settle();
        idle_cycle();
        while (pending_count != 0 || busy) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        int  raw_across, raw_down, raw_serp, cols, rows, stream_len, idle_pct;
        logic op;
        int  x, y, bi;

        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = CFG_PANELS_ACROSS;
        cfg_data   = '0;
        start      = 1'b0;
        mode       = MODE_WRITE;
        pixel_x    = '0;
        pixel_y    = '0;
        pixel_on   = 1'b0;
        scan_phase = '0;
        byte_index = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Waits out the clearing sweep that follows reset.
        settle();

        // ---- directed: default single panel, corners and edges ----
        issue(MODE_WRITE, 0, 0, 1, 2'd3, 8'hff);     // unused read fields set
        issue(MODE_WRITE, 31, 15, 1, 0, 0);
        issue(MODE_WRITE, 31, 0, 1, 0, 0);
        issue(MODE_WRITE, 0, 15, 1, 0, 0);
        issue(MODE_WRITE, 32, 0, 1, 0, 0);           // just past the right edge
        issue(MODE_WRITE, 0, 16, 1, 0, 0);           // just past the bottom edge
        issue(MODE_WRITE, 511, 255, 1, 0, 0);        // far corner of the field
        issue(MODE_READ, 511, 255, 1, 0, 3);         // unused write fields set
        issue(MODE_READ, 0, 0, 0, 3, 12);
        issue(MODE_READ, 0, 0, 0, 3, 15);            // last byte of the stream
        issue(MODE_READ, 0, 0, 0, 1, 16);            // first byte past it
        issue(MODE_READ, 0, 0, 0, 2, 255);
        issue(MODE_WRITE, 0, 0, 0, 0, 0);            // clear a lit pixel
        issue(MODE_READ, 0, 0, 0, 0, 3);

        // ---- directed: 5x4 serpentine, more panels than the store holds ----
        settle();
        write_reg(CFG_PANELS_ACROSS, 5'd5);
        write_reg(CFG_PANELS_DOWN, 5'd4);
        write_reg(CFG_SERPENTINE, 5'd1);
        write_reg(CFG_SPARE_INDEX, 5'd31);           // must change nothing
        issue(MODE_WRITE, 0, 16, 1, 0, 0);           // odd row, mirrored x
        issue(MODE_WRITE, 159, 16, 1, 0, 0);
        issue(MODE_WRITE, 0, 48, 1, 0, 0);           // maps past panel capacity
        issue(MODE_WRITE, 128, 48, 1, 0, 0);         // last panel that fits
        issue(MODE_WRITE, 64, 32, 1, 0, 0);          // even row, straight order
        issue(MODE_WRITE, 160, 0, 0, 0, 0);          // off the right side
        issue(MODE_WRITE, 0, 64, 1, 0, 0);           // off the bottom
        issue(MODE_READ, 0, 0, 0, 0, 255);
        issue(MODE_READ, 0, 0, 0, 0, 9 * 16 + 12);
        issue(MODE_READ, 0, 0, 0, 3, 0);

        // ---- random rounds, each with its own geometry ----
        for (int r = 0; r < ROUNDS; r++)
        begin
            case (r)
                0:
                begin
                    raw_across = 1;  raw_down = 1;  raw_serp = 0;
                end
                1:
                begin
                    raw_across = 16; raw_down = 1;  raw_serp = 0;
                end
                2:
                begin
                    raw_across = 1;  raw_down = 16; raw_serp = 1;
                end
                3:
                begin
                    raw_across = 4;  raw_down = 4;  raw_serp = 1;
                end
                4:
                begin
                    raw_across = 0;  raw_down = 0;  raw_serp = 0;
                end
                5:
                begin
                    raw_across = 31; raw_down = 31; raw_serp = 1;
                end
                6:
                begin
                    raw_across = 2;  raw_down = 8;  raw_serp = 1;
                end
                7:
                begin
                    raw_across = 17; raw_down = 2;  raw_serp = 0;
                end
                8:
                begin
                    raw_across = 5;  raw_down = 5;  raw_serp = 1;
                end
                9:
                begin
                    raw_across = 8;  raw_down = 2;  raw_serp = 1;
                end
                10:
                begin
                    raw_across = 3;  raw_down = 3;  raw_serp = 0;
                end
                default:
                begin
                    raw_across = 16; raw_down = 16; raw_serp = 0;
                end
            endcase
            // sender idles 29% of cycles, then 58%, then runs back to back
            idle_pct = (r < 4) ? 29 : (r < 8) ? 58 : 0;

            settle();
            write_reg(CFG_PANELS_ACROSS, 5'(raw_across));
            write_reg(CFG_PANELS_DOWN, 5'(raw_down));
            write_reg(CFG_SERPENTINE, 5'(raw_serp));
            write_reg(CFG_SPARE_INDEX, 5'($urandom));

            // effective geometry, used only to keep most traffic on the display
            cols = 32 * ((raw_across == 0) ? 1 : (raw_across > 16) ? 16 : raw_across);
            rows = 16 * ((raw_down == 0) ? 1 : (raw_down > 16) ? 16 : raw_down);
            stream_len = (cols / 32) * (rows / 16);
            if (stream_len > 16) stream_len = 16;
            stream_len = 16 * stream_len;

            for (int n = 0; n < ITEMS_PER_ROUND; n++)
            begin
                while ($urandom_range(99) < idle_pct) idle_cycle();
                op = ($urandom_range(99) < 55) ? MODE_WRITE : MODE_READ;
                // one in ten draws spans the whole field to hit the clipping paths
                x  = ($urandom_range(9) == 0) ? $urandom_range(511)
                                              : $urandom_range(cols - 1);
                y  = ($urandom_range(9) == 0) ? $urandom_range(255)
                                              : $urandom_range(rows - 1);
                bi = ($urandom_range(9) == 0) ? $urandom_range(255)
                                              : $urandom_range(stream_len - 1);
                issue(op, 9'(x), 8'(y), ($urandom_range(99) < 65), 2'($urandom), 8'(bi));
            end
        end

        settle();
        if (mismatch_count == 0)
            $display("led_panel_scan_buffer test passed");
        else
            $display("led_panel_scan_buffer test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run (reset sweep plus ~2k
    // transactions with heavy idling).
    initial
    begin
        #2_000_000;
        $display("led_panel_scan_buffer test failed");
        $finish;
    end

endmodule
